@@ rtl/stbs_pkg.sv @@
`timescale 1ns / 1ps

package stbs_pkg;

  // Widths of the transaction fields.
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 2;
  localparam int OIDX_W   = 10;

  // Default number of table entries.
  localparam int DEF_TABLE_DEPTH = 1024;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ASSIGN = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ORDER     = 2'd3;

  // Tag value that means no tag is assigned.
  localparam logic signed [TAG_W-1:0] NO_TAG = -16'sd1;

  // One result transaction.
  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [TAG_W-1:0] tag;
    logic [OIDX_W-1:0]       index;
  } res_t;

endpackage

@@ rtl/stbs_mem.sv @@
`timescale 1ns / 1ps

// Simple dual-port memory with one write port and one registered read port.
module stbs_mem #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/sorted_table_binary_search.sv @@
`timescale 1ns / 1ps

// Sorted key table with binary search.
// Input channel (in_valid, in_stall) carries one command transaction: cmd, search_key and
// tag_value. Append adds an entry at the end of the table, lookup finds a key and returns
// its tag and position, and assign finds a key and overwrites its tag. Every command gives
// exactly one result transaction on the output channel (out_valid, out_stall): status,
// found_tag and found_index.
// Append or unused command: the result goes to the done state and is loaded into the
// output register, raising out_valid, once that register is free. A lookup or assign
// first runs the binary search, at most ceil(log2(entries + 1)) probes, so up to 11
// probes for a full table of 1024 entries. Each probe waits for the registered read of
// the key memory before the search window narrows.
// One command is in flight at a time; in_stall is high while a command is being worked
// on or its result waits for a free output register.
// The output register holds a result while out_stall is high, and the next command is
// already accepted then; its result waits inside the block until the register frees.
// Synchronous reset empties the table (entry count zero) and drops any pending result.
// The key and tag memories themselves are not cleared.
module sorted_table_binary_search
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [CMD_W-1:0]           cmd,
  input  logic [KEY_W-1:0]           search_key,
  input  logic signed [TAG_W-1:0]    tag_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        status,
  output logic signed [TAG_W-1:0]    found_tag,
  output logic [OIDX_W-1:0]          found_index
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DONE   = 2'd2;

  logic [1:0]              state;
  logic [CNT_W-1:0]        entry_count;
  logic [KEY_W-1:0]        last_key;
  logic [CMD_W-1:0]        cmd_q;
  logic [KEY_W-1:0]        key_q;
  logic signed [TAG_W-1:0] tag_q;
  logic [CNT_W-1:0]        lo;
  logic [CNT_W-1:0]        hi;
  logic [IDX_W-1:0]        mid;
  res_t                    pend;

  logic [KEY_W-1:0]        key_rd;
  logic [TAG_W-1:0]        tag_rd;

  logic                    acc;
  logic                    table_full;
  logic                    append_ok;
  logic                    first_rd;
  logic                    hit;
  logic                    cont_rd;
  logic [CNT_W-1:0]        lo_next;
  logic [CNT_W-1:0]        hi_next;
  logic [CNT_W-1:0]        mid_wide;
  logic [IDX_W-1:0]        mid_next;
  logic [IDX_W-1:0]        half_count;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic                    tag_we;
  logic [IDX_W-1:0]        tag_wa;
  logic [TAG_W-1:0]        tag_wd;
  logic [IDX_W+OIDX_W-1:0] count_ext;
  logic [IDX_W+OIDX_W-1:0] mid_ext;
  logic                    out_free;

  assign in_stall = (state != S_IDLE);
  assign acc      = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign table_full = (entry_count == CNT_W'(TABLE_DEPTH));
  assign append_ok  = acc && (cmd == CMD_APPEND) && !table_full &&
                      !((entry_count != '0) && (search_key <= last_key));

  // Positions are reported in a fixed 10-bit field, low bits of the entry index.
  assign count_ext = {{OIDX_W{1'b0}}, entry_count[IDX_W-1:0]};
  assign mid_ext   = {{OIDX_W{1'b0}}, mid};

  // The first probe sits at the middle of the filled part of the table.
  assign half_count = IDX_W'(entry_count >> 1);

  // Hit detection at mid, and narrowing of the search window after a miss at mid.
  assign hit = (state == S_SEARCH) && (key_rd == key_q);

  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (key_rd > key_q) begin
      hi_next = CNT_W'(mid);
    end else begin
      lo_next = CNT_W'(mid) + CNT_W'(1);
    end
    mid_wide = lo_next + ((hi_next - lo_next) >> 1);
    mid_next = mid_wide[IDX_W-1:0];
  end

  always_comb begin
    first_rd = 1'b0;
    if (acc && (cmd inside {CMD_LOOKUP, CMD_ASSIGN}) && (entry_count != '0)) begin
      first_rd = 1'b1;
    end
  end

  assign cont_rd = (state == S_SEARCH) && !hit && (lo_next < hi_next);
  assign rd_en   = first_rd || cont_rd;
  assign rd_addr = first_rd ? half_count : mid_next;

  // The tag memory is written by a successful append or by an assign that hits.
  always_comb begin
    tag_we = 1'b0;
    tag_wa = entry_count[IDX_W-1:0];
    tag_wd = tag_value;
    if (append_ok) begin
      tag_we = 1'b1;
    end else if (hit && (cmd_q == CMD_ASSIGN)) begin
      tag_we = 1'b1;
      tag_wa = mid;
      tag_wd = tag_q;
    end
  end

  stbs_mem #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_mem (
    .clk     (clk),
    .wr_en   (append_ok),
    .wr_addr (entry_count[IDX_W-1:0]),
    .wr_data (search_key),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (key_rd)
  );

  stbs_mem #(
    .WIDTH (TAG_W),
    .DEPTH (TABLE_DEPTH)
  ) u_tag_mem (
    .clk     (clk),
    .wr_en   (tag_we),
    .wr_addr (tag_wa),
    .wr_data (tag_wd),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (tag_rd)
  );

  // Control: sequencer state, entry count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            if (first_rd) begin
              state <= S_SEARCH;
            end else begin
              state <= S_DONE;
            end
            if (append_ok) begin
              entry_count <= entry_count + CNT_W'(1);
            end
          end
        end
        S_SEARCH: begin
          if (hit || !cont_rd) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: command copy, search window, pending and output result.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (acc) begin
          cmd_q    <= cmd;
          key_q    <= search_key;
          tag_q    <= tag_value;
          lo       <= '0;
          hi       <= entry_count;
          mid      <= half_count;
          pend.tag <= NO_TAG;
          if (append_ok) begin
            pend.status <= ST_OK;
            pend.index  <= count_ext[OIDX_W-1:0];
            last_key    <= search_key;
          end else begin
            pend.index <= '0;
            if (cmd != CMD_APPEND) begin
              pend.status <= ST_NOT_FOUND;
            end else if (table_full) begin
              pend.status <= ST_FULL;
            end else begin
              pend.status <= ST_ORDER;
            end
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          pend.status <= ST_OK;
          pend.index  <= mid_ext[OIDX_W-1:0];
          if (cmd_q == CMD_LOOKUP) begin
            pend.tag <= tag_rd;
          end
        end else begin
          lo  <= lo_next;
          hi  <= hi_next;
          mid <= mid_next;
        end
      end
      S_DONE: begin
        if (out_free) begin
          status      <= pend.status;
          found_tag   <= pend.tag;
          found_index <= pend.index;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // The table never holds more entries than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // One command at a time: after an accepted transaction the input is stalled.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    acc |=> in_stall)
    else $error("input accepted while a command is in flight");

  // A probe is only outstanding while the search window is not empty.
  a_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (lo < hi) && (CNT_W'(mid) >= lo) && (CNT_W'(mid) < hi))
    else $error("probe outside the search window");

  // The entry count only moves on an accepted append.
  a_count_change: assert property (@(posedge clk) disable iff (rst)
    (entry_count != $past(entry_count)) |->
      ($past(in_valid) && !$past(in_stall) && ($past(cmd) == CMD_APPEND)))
    else $error("entry count changed without an append");
`endif

endmodule

@@ bench/tb_sorted_table_binary_search.sv @@
`timescale 1ns / 1ps

// The bench drives command transactions into the sorted table, predicts every result
// transaction with its own copy of the table, and compares the two field by field.
module tb_sorted_table_binary_search
  import stbs_pkg::*;
();

  localparam int DEPTH          = DEF_TABLE_DEPTH;
  localparam int RANDOM_ITEMS   = 1700;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;

  // The package names the three real commands; code three is unused but still legal.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Keeps a private copy of the table. Every accepted command is applied to that copy
  // as soon as it is accepted, and the answer it must produce is queued in order.
  class table_scoreboard;
    logic [KEY_W-1:0]        key_mem [DEPTH];
    logic signed [TAG_W-1:0] tag_mem [DEPTH];
    int unsigned             entries;
    res_t                    answer_q [$];
    int                      errors;

    function new();
      entries = 0;
      errors  = 0;
    endfunction

    // Plain binary search over the valid part of the table. The keys are strictly
    // ascending, so a hit position is unique.
    function bit find_entry(input logic [KEY_W-1:0] key, output int unsigned pos);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo  = 0;
      hi  = entries;
      pos = 0;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (key_mem[mid] == key) begin
          pos = mid;
          return 1'b1;
        end
        if (key_mem[mid] > key) hi = mid;
        else lo = mid + 1;
      end
      return 1'b0;
    endfunction

    function void note_command(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] key,
                               input logic signed [TAG_W-1:0] tg);
      res_t        ans;
      int unsigned pos;
      ans.status = ST_NOT_FOUND;
      ans.tag    = NO_TAG;
      ans.index  = '0;
      case (c)
        CMD_APPEND: begin
          if (entries >= DEPTH) begin
            ans.status = ST_FULL;
          end else if (entries > 0 && key <= key_mem[entries-1]) begin
            ans.status = ST_ORDER;
          end else begin
            key_mem[entries] = key;
            tag_mem[entries] = tg;
            ans.index  = entries[OIDX_W-1:0];
            ans.status = ST_OK;
            entries++;
          end
        end
        CMD_LOOKUP: begin
          if (find_entry(key, pos)) begin
            ans.status = ST_OK;
            ans.tag    = tag_mem[pos];
            ans.index  = pos[OIDX_W-1:0];
          end
        end
        CMD_ASSIGN: begin
          if (find_entry(key, pos)) begin
            tag_mem[pos] = tg;
            ans.status   = ST_OK;
            ans.index    = pos[OIDX_W-1:0];
          end
        end
        default: begin
        end
      endcase
      answer_q.push_back(ans);
    endfunction

    function void check_result(input logic [STATUS_W-1:0] st,
                               input logic signed [TAG_W-1:0] tg,
                               input logic [OIDX_W-1:0] idx);
      res_t ans;
      if (answer_q.size() == 0) begin
        $display("%0t: result with nothing outstanding: status %0d tag %0d index %0d",
                 $time, st, tg, idx);
        errors++;
        return;
      end
      ans = answer_q.pop_front();
      if (st !== ans.status) begin
        $display("%0t: status mismatch: expected %0d, got %0d", $time, ans.status, st);
        errors++;
      end
      if (tg !== ans.tag) begin
        $display("%0t: found_tag mismatch: expected %0d, got %0d", $time, ans.tag, tg);
        errors++;
      end
      if (idx !== ans.index) begin
        $display("%0t: found_index mismatch: expected %0d, got %0d", $time, ans.index, idx);
        errors++;
      end
    endfunction
  endclass

  // All inputs of the block start at known values; reset is high from time zero.
  logic                    clk        = 1'b0;
  logic                    rst        = 1'b1;
  logic                    in_valid   = 1'b0;
  logic                    in_stall;
  logic [CMD_W-1:0]        cmd        = CMD_LOOKUP;
  logic [KEY_W-1:0]        search_key = '0;
  logic signed [TAG_W-1:0] tag_value  = NO_TAG;
  logic                    out_valid;
  logic                    out_stall  = 1'b0;
  logic [STATUS_W-1:0]     status;
  logic signed [TAG_W-1:0] found_tag;
  logic [OIDX_W-1:0]       found_index;

  table_scoreboard sb;
  bit              hold_req    = 1'b0;
  int              burst_left  = 0;
  int              idle_cycles = 0;

  always #10 clk = ~clk;

  sorted_table_binary_search #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .search_key(search_key),
    .tag_value(tag_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .found_tag(found_tag),
    .found_index(found_index)
  );

  // Offers one command transaction and returns once the block has taken it. A random
  // gap with valid low may come first. Bursts of back-to-back transactions are mixed
  // in so that some stretches have no sender idling at all.
  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                          input logic signed [TAG_W-1:0] t);
    int gap;
    int r;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) burst_left = $urandom_range(30, 80);
      else if (r < 50) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 15);
      else gap = $urandom_range(20, 50);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    search_key <= k;
    tag_value  <= t;
    do @(posedge clk); while (in_stall);
    sb.note_command(c, k, t);
  endtask

  // The sender pauses until every outstanding result has come back.
  task automatic wait_drained();
    while (sb.answer_q.size() != 0) @(posedge clk);
  endtask

  // Tags favor NO_TAG, the largest value and zero; the rest are spread over the non-negative range.
  function automatic logic signed [TAG_W-1:0] random_tag();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return NO_TAG;
    if (r == 2) return 16'sh7FFF;
    if (r == 3) return '0;
    return TAG_W'($urandom_range(0, 32767));
  endfunction

  // Keys for lookup and assign: mostly keys in the table, some neighbors of a stored
  // key (which may or may not hit), and some fully random keys.
  function automatic logic [KEY_W-1:0] probe_key();
    int               r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    if (sb.entries == 0 || r >= 85) begin
      k = $urandom();
    end else begin
      k = sb.key_mem[$urandom_range(0, sb.entries - 1)];
      if (r >= 70) k = r[0] ? k + 1 : k - 1;
    end
    return k;
  endfunction

  // Keys for append. An in-order key lies a random step above the last key, and the
  // very last entry of the table gets the largest possible key. An out-of-order key
  // is either equal to the last key or somewhere below it.
  function automatic logic [KEY_W-1:0] append_key(input bit in_order);
    logic [KEY_W-1:0] last;
    last = (sb.entries > 0) ? sb.key_mem[sb.entries - 1] : '0;
    if (in_order) begin
      if (sb.entries == DEPTH - 1) return '1;
      return last + $urandom_range(1, 1 << 21);
    end
    if ($urandom_range(0, 1) == 0) return last;
    return $urandom_range(0, last);
  endfunction

  // Receiver: out_stall follows a random pattern of short, medium and rare long
  // stalls, with stretches of no stall at all. When the sender asks for it, the
  // receiver holds off for a long stretch so the block backs up and stalls its input.
  initial begin : receiver
    int r;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (r < 45) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(50, 200)) @(posedge clk);
        end else if (r < 88) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else if (r < 97) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(4, 15)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end
      end
    end
  end

  // Result monitor. The outputs and out_stall are read at the edge before any
  // nonblocking update lands, so this sees exactly what the block saw.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(status, found_tag, found_index);
  end

  // Watchdog: any accepted transaction on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sorted_table_binary_search test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int r;
    int share;
    int n;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The empty table must answer not found for lookup and assign,
    // and the unused command code must change nothing.
    send_cmd(CMD_LOOKUP, 32'h0000_0000, NO_TAG);
    send_cmd(CMD_ASSIGN, 32'h0000_0000, 16'sh7FFF);
    send_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 16'sh7FFF);
    // Smallest key first, then a repeat of it, which is out of order.
    send_cmd(CMD_APPEND, 32'h0000_0000, NO_TAG);
    send_cmd(CMD_APPEND, 32'h0000_0000, 16'sh0001);
    send_cmd(CMD_LOOKUP, 32'h0000_0000, '0);
    send_cmd(CMD_APPEND, 32'd100, 16'sh7FFF);
    send_cmd(CMD_APPEND, 32'd50, '0);
    send_cmd(CMD_LOOKUP, 32'd100, NO_TAG);
    // A key between two stored keys and one above all of them are both misses.
    send_cmd(CMD_LOOKUP, 32'd50, NO_TAG);
    send_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, NO_TAG);
    // Assign reports the position with no tag, and the lookup sees the new tag.
    send_cmd(CMD_ASSIGN, 32'h0000_0000, 16'sh7FFF);
    send_cmd(CMD_LOOKUP, 32'h0000_0000, NO_TAG);
    send_cmd(CMD_ASSIGN, 32'd77, '0);
    send_cmd(CMD_UNUSED, 32'd100, '0);
    send_cmd(CMD_APPEND, 32'd101, '0);
    send_cmd(CMD_ASSIGN, 32'd101, NO_TAG);
    send_cmd(CMD_LOOKUP, 32'd101, '0);
    in_valid <= 1'b0;
    wait_drained();

    // Random part. Appends dominate so the table fills up; once it is full, most
    // traffic turns to lookups and assigns over the full table. If the item budget
    // runs out first, in-order appends continue until the table is full. Random
    // append keys stay in the lower half of the key space, so in-order keys never wrap.
    for (n = 0; n < RANDOM_ITEMS || sb.entries < DEPTH; n++) begin
      if (n == 300) hold_req = 1'b1;
      if (n == 800 || n == 1400) begin
        in_valid <= 1'b0;
        wait_drained();
      end
      share = (sb.entries >= DEPTH) ? 8 : 72;
      r = $urandom_range(0, 99);
      if (n >= RANDOM_ITEMS) begin
        send_cmd(CMD_APPEND, append_key(1'b1), random_tag());
      end else if (r < share) begin
        r = $urandom_range(0, 99);
        if (r < 94) send_cmd(CMD_APPEND, append_key(1'b1), random_tag());
        else if (r < 98) send_cmd(CMD_APPEND, append_key(1'b0), random_tag());
        else send_cmd(CMD_APPEND, $urandom_range(0, 32'h7FFF_FFFF), random_tag());
      end else if (r < 87) begin
        send_cmd(CMD_LOOKUP, probe_key(), random_tag());
      end else if (r < 96) begin
        send_cmd(CMD_ASSIGN, probe_key(), random_tag());
      end else begin
        send_cmd(CMD_UNUSED, $urandom(), random_tag());
      end
    end

    // The table is full now: appending must report it, and both ends stay reachable.
    send_cmd(CMD_APPEND, 32'hFFFF_FFFF, '0);
    send_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, '0);
    send_cmd(CMD_ASSIGN, 32'hFFFF_FFFF, 16'sh7FFF);
    send_cmd(CMD_LOOKUP, 32'h0000_0000, '0);
    in_valid <= 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.answer_q.size() == 0) begin
      $display("sorted_table_binary_search test passed");
    end else begin
      $display("sorted_table_binary_search test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/stbs_pkg.sv
rtl/stbs_mem.sv
rtl/sorted_table_binary_search.sv
bench/tb_sorted_table_binary_search.sv
